// ===== src/hrlf_pkg.sv =====
// shared constants, types and the header prefix table of the request length framer
package hrlf_pkg;

	localparam int BYTE_W              = 8;
	localparam int LEN_W               = 32;
	localparam int STATUS_W            = 2;
	localparam int CFG_W               = 32;
	localparam int LENGTH_BITS_DEFAULT = 32;
	localparam logic [CFG_W-1:0] MAX_REQUEST_BYTES_RESET = 32'd65535;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_COMPLETE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_LIMIT     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd2;

	// progress through cr lf cr lf
	localparam logic [2:0] TERM_NONE = 3'd0;
	localparam logic [2:0] TERM_CR1  = 3'd1;
	localparam logic [2:0] TERM_LF1  = 3'd2;
	localparam logic [2:0] TERM_CR2  = 3'd3;
	localparam logic [2:0] TERM_LF2  = 3'd4;

	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
	localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

	localparam int PREFIX_LEN = 15;
	localparam int PREFIX_IDX_W = $clog2(PREFIX_LEN);
	localparam logic [PREFIX_IDX_W-1:0] PREFIX_LAST = PREFIX_IDX_W'(PREFIX_LEN - 1);

	// line scanner modes
	typedef enum logic [4:0] {
		SCAN_PREFIX  = 5'b00001,
		SCAN_WS      = 5'b00010,
		SCAN_DIGITS  = 5'b00100,
		SCAN_SKIP    = 5'b01000,
		SCAN_REQLINE = 5'b10000
	} scan_mode_t;

	// "Content-Length:"
	function automatic logic [BYTE_W-1:0] prefix_char(input logic [PREFIX_IDX_W-1:0] idx);
		logic [BYTE_W-1:0] c;
		unique case (idx)
			4'd0:    c = "C";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "L";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			4'd14:   c = ":";
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== src/hrlf_data_if.sv =====
// byte channel into the request length framer
interface hrlf_data_if;
	import hrlf_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== src/hrlf_result_if.sv =====
// result channel out of the request length framer
interface hrlf_result_if;
	import hrlf_pkg::*;

	logic                valid;
	logic                ready;
	logic [LEN_W-1:0]    frame_len;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output frame_len, output status, input ready);
	modport sink   (input valid, input frame_len, input status, output ready);
endinterface

// ===== src/http_request_length_framer.sv =====
// top level of the http/1 request length framer
//
// channel   dir  beat payload                         role
// data      in   data_byte[7:0]                   one request byte per beat
// result    out  frame_len[31:0], status[1:0]     one beat per finished request
// cfg_wr_*  in   cfg_wr_data[31:0]                max_request_bytes, written when enabled
//
// one byte per cycle sustained; every byte goes through one shallow update of the
// request state (count, terminator match, line scanner, length accumulator)
// a result shows up in the cycle after the byte that ends its request, in an output
// register; a new byte is taken while it waits only if the result leaves that cycle
// arst_n clears all request state and sets max_request_bytes to 65535
// a stalled result holds off every byte for as long as the output register stays full
module http_request_length_framer #(
	parameter int LENGTH_BITS = hrlf_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [hrlf_pkg::CFG_W-1:0]  cfg_wr_data,
	hrlf_data_if.sink                   data,
	hrlf_result_if.source               result
);
	import hrlf_pkg::*;

	// lengths clip at 2^min(LENGTH_BITS,32)-1
	localparam int EFF_BITS = (LENGTH_BITS >= 32) ? 32 : LENGTH_BITS;
	localparam logic [LEN_W:0] LEN_MAX = (33'(1) << EFF_BITS) - 33'(1);

	// configuration and request state
	logic [CFG_W-1:0]        max_req_q;
	logic [LEN_W-1:0]        byte_count_q;
	logic                    headers_done_q;
	logic [2:0]              term_q;
	scan_mode_t              mode_q;
	logic [PREFIX_IDX_W-1:0] prefix_idx_q;
	logic [EFF_BITS-1:0]     acc_q;
	logic                    found_q;
	logic [EFF_BITS-1:0]     total_q;
	logic                    sat_q;

	// next request state
	logic [LEN_W-1:0]        n_byte_count;
	logic                    n_headers_done;
	logic [2:0]              n_term;
	scan_mode_t              n_mode;
	logic [PREFIX_IDX_W-1:0] n_prefix_idx;
	logic [EFF_BITS-1:0]     n_acc;
	logic                    n_found;
	logic [EFF_BITS-1:0]     n_total;
	logic                    n_sat;

	// per-byte decode
	logic [LEN_W:0]        count_inc;
	logic                  over_limit;
	logic                  prev_cr;
	logic                  is_digit;
	logic [3:0]            digit_val;
	logic [EFF_BITS+3:0]   acc_times10;
	logic [LEN_W:0]        total_sum;
	logic                  emit;
	logic [LEN_W-1:0]      emit_len;
	logic [STATUS_W-1:0]   emit_status;

	// output register
	logic                  out_valid_q;
	logic [LEN_W-1:0]      out_len_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic                  accept;

	// a byte may enter whenever the output register is free or being drained
	assign data.ready = !out_valid_q || result.ready;
	assign accept     = data.valid && data.ready;

	assign count_inc  = {1'b0, byte_count_q} + 33'(1);
	assign over_limit = count_inc > {1'b0, max_req_q};
	assign prev_cr    = (term_q == TERM_CR1) || (term_q == TERM_CR2);
	assign is_digit   = (data.data_byte >= CHAR_ZERO) && (data.data_byte <= CHAR_NINE);
	// ascii digits carry their value in the low nibble
	assign digit_val  = data.data_byte[3:0];
	// times ten as shift and add, wide enough that it cannot wrap
	assign acc_times10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ (EFF_BITS+4)'(digit_val);

	always_comb begin
		n_byte_count   = byte_count_q;
		n_headers_done = headers_done_q;
		n_term         = term_q;
		n_mode         = mode_q;
		n_prefix_idx   = prefix_idx_q;
		n_acc          = acc_q;
		n_found        = found_q;
		n_total        = total_q;
		n_sat          = sat_q;
		total_sum      = '0;
		emit           = 1'b0;
		emit_len       = '0;
		emit_status    = STATUS_COMPLETE;

		if (over_limit) begin
			// byte dropped, request thrown away
			emit        = 1'b1;
			emit_status = STATUS_LIMIT;
		end else begin
			n_byte_count = count_inc[LEN_W-1:0];

			if (!headers_done_q) begin
				// blank line detector
				priority if (data.data_byte == CHAR_CR) begin
					n_term = (term_q == TERM_LF1) ? TERM_CR2 : TERM_CR1;
				end else if (data.data_byte == CHAR_LF) begin
					n_term = (term_q == TERM_CR1) ? TERM_LF1 :
					         (term_q == TERM_CR2) ? TERM_LF2 : TERM_NONE;
				end else begin
					n_term = TERM_NONE;
				end

				// content-length line scanner
				unique case (mode_q)
					SCAN_PREFIX: begin
						if (found_q || data.data_byte != prefix_char(prefix_idx_q)) begin
							n_mode = SCAN_SKIP;
						end else if (prefix_idx_q == PREFIX_LAST) begin
							n_mode = SCAN_WS;
						end else begin
							n_prefix_idx = prefix_idx_q + PREFIX_IDX_W'(1);
						end
					end
					SCAN_WS: begin
						if (is_digit) begin
							n_acc  = EFF_BITS'(digit_val);
							n_sat  = 1'b0;
							n_mode = SCAN_DIGITS;
						end else if (data.data_byte != CHAR_SPACE
						             && data.data_byte != CHAR_TAB) begin
							n_mode = SCAN_SKIP;
						end
					end
					SCAN_DIGITS: begin
						if (is_digit) begin
							if (|acc_times10[EFF_BITS+3:EFF_BITS]) begin
								n_acc = LEN_MAX[EFF_BITS-1:0];
								n_sat = 1'b1;
							end else begin
								n_acc = acc_times10[EFF_BITS-1:0];
							end
						end else begin
							n_found = 1'b1;
							n_mode  = SCAN_SKIP;
						end
					end
					SCAN_SKIP, SCAN_REQLINE: begin
						// wait for the end of the line
					end
					default: begin
						n_mode = SCAN_SKIP;
					end
				endcase

				// every cr lf starts a new header line
				if (data.data_byte == CHAR_LF && prev_cr) begin
					n_mode       = SCAN_PREFIX;
					n_prefix_idx = '0;
				end

				// end of headers: header bytes plus body length
				if (n_term == TERM_LF2) begin
					total_sum = count_inc + (n_found ? (LEN_W+1)'(n_acc) : '0);
					if (!n_found) begin
						n_sat = 1'b0;
					end
					if (total_sum > LEN_MAX) begin
						total_sum = LEN_MAX;
						n_sat     = 1'b1;
					end
					n_total        = total_sum[EFF_BITS-1:0];
					n_headers_done = 1'b1;
				end
			end

			if (n_headers_done && count_inc[LEN_W-1:0] >= LEN_W'(n_total)) begin
				emit        = 1'b1;
				emit_len    = LEN_W'(n_total);
				emit_status = n_sat ? STATUS_SATURATED : STATUS_COMPLETE;
			end
		end

		// a result ends the request
		if (emit) begin
			n_byte_count   = '0;
			n_headers_done = 1'b0;
			n_term         = TERM_NONE;
			n_mode         = SCAN_REQLINE;
			n_prefix_idx   = '0;
			n_acc          = '0;
			n_found        = 1'b0;
			n_total        = '0;
			n_sat          = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_req_q <= MAX_REQUEST_BYTES_RESET;
		end else if (cfg_wr_en) begin
			max_req_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			headers_done_q <= 1'b0;
			term_q         <= TERM_NONE;
			mode_q         <= SCAN_REQLINE;
			prefix_idx_q   <= '0;
			acc_q          <= '0;
			found_q        <= 1'b0;
			total_q        <= '0;
			sat_q          <= 1'b0;
		end else if (accept) begin
			byte_count_q   <= n_byte_count;
			headers_done_q <= n_headers_done;
			term_q         <= n_term;
			mode_q         <= n_mode;
			prefix_idx_q   <= n_prefix_idx;
			acc_q          <= n_acc;
			found_q        <= n_found;
			total_q        <= n_total;
			sat_q          <= n_sat;
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_len_q    <= emit_len;
			out_status_q <= emit_status;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.frame_len = out_len_q;
	assign result.status    = out_status_q;

endmodule

// ===== bench/tb_http_request_length_framer.sv =====
// self-checking bench for the http request length framer, directed and random byte streams
`timescale 1ns / 1ps

module tb_http_request_length_framer;
	import hrlf_pkg::*;

	// a narrow length setting for the framer, the cap sits at 65535
	localparam int FRAMER_LEN_BITS = 16;
	localparam int CAP_BITS = (FRAMER_LEN_BITS >= 32) ? 32 : FRAMER_LEN_BITS;
	localparam logic [63:0] LEN_CAP = (64'd1 << CAP_BITS) - 64'd1;
	localparam logic [8*PREFIX_LEN-1:0] CL_PREFIX = "Content-Length:";
	localparam int HOLD_LEN = 400;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [LEN_W-1:0]    len;
		logic [STATUS_W-1:0] status;
	} frame_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;

	hrlf_data_if   byte_ch ();
	hrlf_result_if frame_ch ();

	http_request_length_framer #(
		.LENGTH_BITS(FRAMER_LEN_BITS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.data       (byte_ch),
		.result     (frame_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// stimulus and expected results
	logic [BYTE_W-1:0] tx_bytes[$];
	frame_t            expected_frames[$];
	frame_t            oldest_frame;

	int unsigned bytes_queued = 0;
	int unsigned bytes_accepted = 0;
	int unsigned frames_seen = 0;
	int unsigned limit_seen = 0;
	int unsigned clipped_seen = 0;
	int unsigned cfg_writes = 0;
	int unsigned error_count = 0;
	int unsigned stall_cycles = 0;
	int unsigned hold_cycles = 0;
	int          send_idle_pct;
	int          recv_idle_pct;
	logic        hold_arm = 1'b0;

	// predictor copy of the framer state
	logic [CFG_W-1:0] max_bytes;
	logic [31:0]      req_bytes;
	logic             hdr_done;
	logic [2:0]       crlf_match;
	scan_mode_t       scan_mode;
	int               prefix_idx;
	logic [63:0]      len_acc;
	logic             len_found;
	logic [63:0]      total_len;
	logic             len_clipped;

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count = error_count + 1;
	endtask

	task automatic clear_request_state();
		req_bytes   = '0;
		hdr_done    = 1'b0;
		crlf_match  = TERM_NONE;
		scan_mode   = SCAN_REQLINE;
		prefix_idx  = 0;
		len_acc     = '0;
		len_found   = 1'b0;
		total_len   = '0;
		len_clipped = 1'b0;
	endtask

	task automatic queue_frame(input logic [LEN_W-1:0] len, input logic [STATUS_W-1:0] status);
		frame_t f;
		f.len    = len;
		f.status = status;
		expected_frames.push_back(f);
	endtask

	// one accepted byte through the framer state, queues the result it causes
	task automatic frame_byte(input logic [BYTE_W-1:0] b);
		logic [63:0] count;
		logic [63:0] next_acc;
		logic [63:0] digit_val;
		logic        prev_cr;
		logic        is_digit;
		logic [2:0]  t;
		count = {32'd0, req_bytes} + 64'd1;
		if (count > {32'd0, max_bytes}) begin
			// over the byte limit: the byte is dropped and the request starts over
			clear_request_state();
			queue_frame('0, STATUS_LIMIT);
		end else begin
			req_bytes = count[31:0];
			if (!hdr_done) begin
				prev_cr = (crlf_match == TERM_CR1) || (crlf_match == TERM_CR2);
				if (b == CHAR_CR) begin
					t = (crlf_match == TERM_LF1) ? TERM_CR2 : TERM_CR1;
				end else if (b == CHAR_LF) begin
					t = (crlf_match == TERM_CR1) ? TERM_LF1 :
						(crlf_match == TERM_CR2) ? TERM_LF2 : TERM_NONE;
				end else begin
					t = TERM_NONE;
				end
				crlf_match = t;

				is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
				digit_val = {56'd0, b} - {56'd0, CHAR_ZERO};
				case (scan_mode)
					SCAN_PREFIX: begin
						// once a length is found, no later header is matched
						if (len_found || b != CL_PREFIX[8*(PREFIX_LEN-1-prefix_idx) +: 8]) begin
							scan_mode = SCAN_SKIP;
						end else if (prefix_idx == PREFIX_LEN - 1) begin
							scan_mode = SCAN_WS;
						end else begin
							prefix_idx = prefix_idx + 1;
						end
					end
					SCAN_WS: begin
						if (is_digit) begin
							len_acc     = digit_val;
							len_clipped = 1'b0;
							scan_mode   = SCAN_DIGITS;
						end else if (b != CHAR_SPACE && b != CHAR_TAB) begin
							scan_mode = SCAN_SKIP;
						end
					end
					SCAN_DIGITS: begin
						if (is_digit) begin
							next_acc = len_acc * 64'd10 + digit_val;
							if (len_acc > LEN_CAP / 64'd10 || next_acc > LEN_CAP) begin
								next_acc    = LEN_CAP;
								len_clipped = 1'b1;
							end
							len_acc = next_acc;
						end else begin
							len_found = 1'b1;
							scan_mode = SCAN_SKIP;
						end
					end
					default: ;
				endcase
				// only cr lf starts a new line
				if (b == CHAR_LF && prev_cr) begin
					scan_mode  = SCAN_PREFIX;
					prefix_idx = 0;
				end

				if (t == TERM_LF2) begin
					total_len = count + (len_found ? len_acc : 64'd0);
					if (!len_found)
						len_clipped = 1'b0;
					if (total_len > LEN_CAP) begin
						total_len   = LEN_CAP;
						len_clipped = 1'b1;
					end
					hdr_done = 1'b1;
				end
			end
			if (hdr_done && count >= total_len) begin
				queue_frame(total_len[LEN_W-1:0], len_clipped ? STATUS_SATURATED : STATUS_COMPLETE);
				clear_request_state();
			end
		end
	endtask

	// ---------------------------------------------------------------- stimulus builders

	task automatic queue_byte(input logic [BYTE_W-1:0] b);
		tx_bytes.push_back(b);
		bytes_queued = bytes_queued + 1;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i]);
	endtask

	task automatic push_random_bytes(input int unsigned n);
		repeat (n) queue_byte(8'($urandom_range(0, 255)));
	endtask

	// random bytes that never end a line
	task automatic push_line_bytes(input int unsigned n);
		logic [BYTE_W-1:0] b;
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			if (b == CHAR_CR || b == CHAR_LF)
				b = "a";
			queue_byte(b);
		end
	endtask

	task automatic push_blanks();
		repeat ($urandom_range(0, 2))
			queue_byte(($urandom_range(0, 1) != 0) ? CHAR_SPACE : CHAR_TAB);
	endtask

	task automatic push_filler_header();
		push_line_bytes($urandom_range(1, 4));
		push_text(": ");
		push_line_bytes($urandom_range(0, 4));
		push_text("\r\n");
	endtask

	// content length line, leading zeros and trailing junk now and then
	task automatic push_length_header(input int unsigned v);
		push_text("Content-Length:");
		push_blanks();
		repeat ($urandom_range(0, 2)) queue_byte(CHAR_ZERO);
		push_text($sformatf("%0d", v));
		if ($urandom_range(0, 3) == 0)
			push_text(" ;q");
		push_text("\r\n");
	endtask

	// one request, mostly well formed with random content
	task automatic push_request();
		int unsigned pick;
		int unsigned body_len;
		logic        has_len;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			// plain noise, cr and lf included
			push_random_bytes($urandom_range(1, 12));
		end else begin
			push_line_bytes($urandom_range(1, 6));
			push_text("\r\n");
			has_len  = ($urandom_range(0, 3) != 0);
			body_len = $urandom_range(0, 40);
			repeat ($urandom_range(0, 2)) push_filler_header();
			case (pick)
				1: begin
					// no digits after the colon, later lines still count
					push_text("Content-Length:");
					push_blanks();
					push_text("x\r\n");
				end
				2: push_text("content-length: 7\r\n");
				3: push_text("Content-Lengt: 7\r\n");
				4: push_text("X:\nContent-Length: 7\r\n");
				default: ;
			endcase
			if (has_len)
				push_length_header(body_len);
			if (pick == 5)
				push_length_header($urandom_range(0, 40));
			repeat ($urandom_range(0, 1)) push_filler_header();
			// a missing blank line runs the body into the headers
			if (pick != 6)
				push_text("\r\n");
			if (has_len)
				push_random_bytes(body_len);
		end
	endtask

	task automatic push_random(input int unsigned n);
		int unsigned stop_at;
		stop_at = bytes_queued + n;
		while (bytes_queued < stop_at)
			push_request();
	endtask

	// ---------------------------------------------------------------- sequencing helpers

	// every queued byte taken and every expected result back, then a short settle
	task automatic wait_drained();
		do
			@(posedge clk);
		while (bytes_accepted != bytes_queued || expected_frames.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [CFG_W-1:0] limit);
		cfg_wr_data <= limit;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		max_bytes  = limit;
		cfg_writes = cfg_writes + 1;
	endtask

	task automatic start_phase(input logic [CFG_W-1:0] limit);
		wait_drained();
		if (req_bytes != 0) begin
			// one byte against a limit of one throws away a request left open
			write_limit(32'd1);
			queue_byte(8'($urandom_range(0, 255)));
			wait_drained();
		end
		write_limit(limit);
	endtask

	// ---------------------------------------------------------------- driver

	// offers the next pending byte, holds it until the beat is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid     <= 1'b0;
			byte_ch.data_byte <= '0;
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				frame_byte(byte_ch.data_byte);
				bytes_accepted = bytes_accepted + 1;
			end
			if (!byte_ch.valid || byte_ch.ready) begin
				if (tx_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					byte_ch.valid     <= 1'b1;
					byte_ch.data_byte <= tx_bytes.pop_front();
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver hold-off

	// one long stretch with the receiver closed so the output register fills
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_cycles <= 0;
		else if (hold_arm && hold_cycles < HOLD_LEN)
			hold_cycles <= hold_cycles + 1;
	end

	wire receiver_held = hold_arm && (hold_cycles < HOLD_LEN);

	// ---------------------------------------------------------------- monitor

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ch.ready <= 1'b0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				if (expected_frames.size() == 0) begin
					flag_error($sformatf("result beat with nothing expected: length %0d status %0d",
						frame_ch.frame_len, frame_ch.status));
				end else begin
					oldest_frame = expected_frames.pop_front();
					if (frame_ch.frame_len !== oldest_frame.len)
						flag_error($sformatf("frame_len %0d, expected %0d",
							frame_ch.frame_len, oldest_frame.len));
					if (frame_ch.status !== oldest_frame.status)
						flag_error($sformatf("status %0d, expected %0d",
							frame_ch.status, oldest_frame.status));
					frames_seen = frames_seen + 1;
					if (oldest_frame.status == STATUS_LIMIT)
						limit_seen = limit_seen + 1;
					if (oldest_frame.status == STATUS_SATURATED)
						clipped_seen = clipped_seen + 1;
				end
			end
			frame_ch.ready <= !receiver_held && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------- watchdog

	// counts cycles with work outstanding and no beat moving on either side
	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (frame_ch.valid && frame_ch.ready)
				|| (bytes_accepted == bytes_queued && expected_frames.size() == 0))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", stall_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------- test sequence

	initial begin
		arst_n            = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		frame_ch.ready    = 1'b0;
		max_bytes         = MAX_REQUEST_BYTES_RESET;
		clear_request_state();
		// sender mostly busy, receiver mostly idle
		send_idle_pct = 21;
		recv_idle_pct = 81;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// directed requests at the reset limit
		// empty request line, no headers: total is just the four terminator bytes
		push_text("\r\n\r\n");
		// tab and space before the digits, body with zero, all-ones and cr bytes
		push_text("G\r\nContent-Length:\t 3\r\n\r\n");
		queue_byte(8'h00);
		queue_byte(8'hff);
		queue_byte(CHAR_CR);
		// a length header on the request line does not count
		push_text("Content-Length: 1\r\n\r\n");
		// header without digits skipped, value ends at a non-digit, later headers ignored
		push_text("G\r\nContent-Length: z\r\nContent-Length:02x\r\nContent-Length:5\r\n\r\nab");
		push_random(250);

		// largest limit
		start_phase(32'hffff_ffff);
		push_random(250);

		// sender mostly idle, receiver mostly ready
		start_phase(32'd1);
		send_idle_pct <= 81;
		recv_idle_pct <= 21;
		// smallest limit: every second byte of a request is over it
		push_random(120);

		// a tight limit cuts many requests short, some end exactly at it
		start_phase(32'd37);
		push_random(400);

		// no idling, plus the long receiver hold-off to back up the input
		start_phase(32'd300);
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		hold_arm      <= 1'b1;
		push_random(400);

		wait_drained();
		repeat (16) @(posedge clk);

		$display("ran %0d bytes through %0d limit writes, %0d results checked",
			bytes_accepted, cfg_writes, frames_seen);
		$display("of those %0d hit the byte limit and %0d had a clipped length",
			limit_seen, clipped_seen);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
